[rtl/i2cms_pkg.sv]
// Package for the I2C master bit sequencer: payload structs, command codes,
// and phase counts. No dependencies.

package i2cms_pkg;

    // Command codes; values match the opcode field.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    // Input transaction as it appears on the ports.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic [3:0] pulse_count;
        logic       sda_in;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nak;
    } out_item_t;

    // Classified tick, queued between front and back.
    typedef struct packed {
        cmd_t       cmd;        // CMD_NONE for no-op or unknown opcode
        logic       read_empty; // read with pulse_count of zero
        logic [3:0] bits_left;  // data bits of a read
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } dec_item_t;

    localparam logic [3:0] NORMAL_PULSES  = 4'd9;
    localparam logic [4:0] START_PHASES   = 5'd4;
    localparam logic [4:0] STOP_PHASES    = 5'd4;
    localparam logic [4:0] WRITE_PHASES   = 5'd19;
    localparam logic [4:0] CLEAR_PHASES   = 5'd22;
    localparam logic [4:0] READ_TAIL      = 5'd3;   // ack low, ack high, final low
    localparam logic [4:0] WR_DATA_PHASES = 5'd16;
    localparam logic [4:0] WR_ACK_HIGH    = 5'd17;
    localparam logic [4:0] CLR_PULSE_END  = 5'd18;
    localparam logic [4:0] CLR_STOP_LOW   = 5'd19;
    localparam logic [4:0] CLR_STOP_HIGH  = 5'd20;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd14;

endpackage

[rtl/i2c_master_bit_sequencer_top.sv]
// Top level of the I2C master bit sequencer: APB register, front decoder,
// phase engine and result queue. Depends on i2cms_pkg and all i2cms_* modules.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  tick in   | push / full          | cmd_item (opcode, tx_byte, ack_level,
//            |                      |   pulse_count, sda_in)
//  result    | empty / pop          | result (scl, sda, busy, done, rx, nak)
//  config    | psel/penable/pwrite  | paddr, pwdata -> phase_ticks at 0x0
//
// One tick transaction is taken per clock while full is low and yields one
// result transaction; the engine retires one tick per cycle while the result
// queue has room, so sustained rate is one per cycle. A result reaches the
// ports through the tick queue and then the result queue, both registered.
// rst_n is asynchronous; it idles the bus (SCL/SDA released)
// and sets phase_ticks to 14. A stalled pop holds the engine once the
// result queue fills; full then rises once the tick queue fills too.

module i2c_master_bit_sequencer_top
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick input
    input  logic        push,
    output logic        full,
    input  in_item_t    cmd_item,
    // results
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] phase_ticks_reg;
    logic       cfg_wr;
    logic       sel_phase;    // address decodes to phase_ticks

    dec_item_t  dec_item;
    logic       dec_empty;
    logic       res_full;
    logic       go;           // engine retires one tick this cycle
    out_item_t  eng_result;

    // ---------------- configuration register ----------------
    assign pready    = 1'b1;
    assign sel_phase = (paddr[2] == 1'b0);
    assign cfg_wr    = psel && penable && pwrite && pready && sel_phase;
    assign prdata    = sel_phase ? {24'd0, phase_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            phase_ticks_reg <= pwdata[7:0];
        end
    end

    // ---------------- front: decode and queue ticks ----------------
    i2cms_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .cmd_item (cmd_item),
        .full     (full),
        .deq      (go),
        .empty    (dec_empty),
        .dec_item (dec_item)
    );

    // Engine advances when a tick is queued and its result has room.
    assign go = !dec_empty && !res_full;

    // ---------------- back: phase engine ----------------
    i2cms_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .dec_item    (dec_item),
        .phase_ticks (phase_ticks_reg),
        .result      (eng_result)
    );

    // ---------------- result queue ----------------
    i2cms_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (go),
        .wr_data (eng_result),
        .rd_en   (pop),
        .rd_data (result),
        .full    (res_full),
        .empty   (empty)
    );

endmodule

[rtl/i2cms_fifo.sv]
// Small register queue with registered storage, used on both sides of the
// sequencer. No package dependency.

module i2cms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/i2cms_front.sv]
// Front end: decodes each input tick into a classified command and queues it.
// Depends on i2cms_pkg and i2cms_fifo.

module i2cms_front
    import i2cms_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  cmd_item,
    output logic      full,
    input  logic      deq,
    output logic      empty,
    output dec_item_t dec_item
);

    dec_item_t  dec_in;
    logic [3:0] pulses_sat;

    assign pulses_sat = (cmd_item.pulse_count > NORMAL_PULSES) ? NORMAL_PULSES
                                                               : cmd_item.pulse_count;

    always_comb
    begin
        dec_in.tx_byte    = cmd_item.tx_byte;
        dec_in.ack_level  = cmd_item.ack_level;
        dec_in.sda_in     = cmd_item.sda_in;
        dec_in.read_empty = (pulses_sat == 4'd0);
        dec_in.bits_left  = pulses_sat - 4'd1;
        unique case (cmd_item.opcode)
            CMD_START: dec_in.cmd = CMD_START;
            CMD_STOP:  dec_in.cmd = CMD_STOP;
            CMD_WRITE: dec_in.cmd = CMD_WRITE;
            CMD_READ:  dec_in.cmd = CMD_READ;
            CMD_CLEAR: dec_in.cmd = CMD_CLEAR;
            default:   dec_in.cmd = CMD_NONE;   // none and unused codes
        endcase
    end

    i2cms_fifo #(
        .WIDTH ($bits(dec_item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (dec_in),
        .rd_en   (deq),
        .rd_data (dec_item),
        .full    (full),
        .empty   (empty)
    );

endmodule

[rtl/i2cms_engine.sv]
// Back end: phase sequencer holding all bus state; one tick per go cycle.
// Depends on i2cms_pkg.

module i2cms_engine
    import i2cms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  dec_item_t dec_item,
    input  logic [7:0] phase_ticks,
    output out_item_t result
);

    cmd_t       cmd_reg, cmd_next;
    logic [4:0] step_reg, step_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_sample_reg, ack_sample_next;
    logic       ack_drive_reg, ack_drive_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       done;

    logic [7:0] pt;
    logic [4:0] two_b;
    logic [4:0] total;

    assign pt = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

    always_comb
    begin
        cmd_next        = cmd_reg;
        step_next       = step_reg;
        bits_next       = bits_reg;
        div_next        = div_reg;
        shift_next      = shift_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_sample_next = ack_sample_reg;
        ack_drive_next  = ack_drive_reg;
        rx_hold_next    = rx_hold_reg;
        done            = 1'b0;

        // Accept a new command only while idle.
        if (cmd_reg == CMD_NONE && dec_item.cmd != CMD_NONE)
        begin
            step_next = '0;
            div_next  = '0;
            if (dec_item.cmd == CMD_READ)
            begin
                if (dec_item.read_empty)
                begin
                    rx_hold_next = '0;
                    done         = 1'b1;
                end
                else
                begin
                    bits_next      = dec_item.bits_left;
                    shift_next     = '0;
                    ack_drive_next = dec_item.ack_level;
                    cmd_next       = CMD_READ;
                end
            end
            else
            begin
                if (dec_item.cmd == CMD_WRITE)
                begin
                    shift_next = dec_item.tx_byte;
                end
                cmd_next = dec_item.cmd;
            end
        end

        // Phase count of the running command, fixed before it may retire.
        two_b = {bits_next, 1'b0};
        unique case (cmd_next)
            CMD_START: total = START_PHASES;
            CMD_STOP:  total = STOP_PHASES;
            CMD_WRITE: total = WRITE_PHASES;
            CMD_READ:  total = two_b + READ_TAIL;
            CMD_CLEAR: total = CLEAR_PHASES;
            default:   total = 5'd0;
        endcase

        if (cmd_next != CMD_NONE)
        begin
            // Line levels of the current phase.
            unique case (cmd_next)
                CMD_START:
                begin
                    unique case (step_next)
                        5'd0: sda_next = 1'b1;
                        5'd1: begin scl_next = 1'b1; sda_next = 1'b1; end
                        5'd2: begin scl_next = 1'b1; sda_next = 1'b0; end
                        default: begin scl_next = 1'b0; sda_next = 1'b0; end
                    endcase
                end
                CMD_STOP:
                begin
                    unique case (step_next)
                        5'd0: scl_next = 1'b0;
                        5'd1: begin scl_next = 1'b0; sda_next = 1'b0; end
                        5'd2: begin scl_next = 1'b1; sda_next = 1'b0; end
                        default: begin scl_next = 1'b1; sda_next = 1'b1; end
                    endcase
                end
                CMD_WRITE:
                begin
                    if (step_next < WR_DATA_PHASES)
                    begin
                        scl_next = step_next[0];
                        sda_next = shift_next[3'd7 - step_next[3:1]];
                    end
                    else
                    begin
                        scl_next = (step_next == WR_ACK_HIGH);
                        sda_next = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (step_next < two_b)
                    begin
                        scl_next = step_next[0];
                        sda_next = 1'b1;
                    end
                    else if (step_next == two_b)
                    begin
                        scl_next = 1'b0;
                        sda_next = ack_drive_next;
                    end
                    else if (step_next == two_b + 5'd1)
                    begin
                        scl_next = 1'b1;
                        sda_next = ack_drive_next;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    if (step_next <= CLR_PULSE_END)
                    begin
                        scl_next = step_next[0];
                        sda_next = 1'b1;
                    end
                    else if (step_next == CLR_STOP_LOW)
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    else if (step_next == CLR_STOP_HIGH)
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                end
                default: ;
            endcase

            div_next = div_next + 8'd1;
            if (div_next >= pt)
            begin
                div_next = '0;
                // Sample on the last tick of the phase.
                if (cmd_next == CMD_WRITE && step_next == WR_ACK_HIGH)
                begin
                    ack_sample_next = dec_item.sda_in;
                end
                else if (cmd_next == CMD_READ && step_next < two_b && step_next[0])
                begin
                    shift_next = {shift_next[6:0], dec_item.sda_in};
                end
                step_next = step_next + 5'd1;
                if (step_next >= total)
                begin
                    if (cmd_next == CMD_READ)
                    begin
                        rx_hold_next = shift_next;
                    end
                    cmd_next  = CMD_NONE;
                    step_next = '0;
                    done      = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.scl_level = scl_next;
        result.sda_level = sda_next;
        result.busy_res  = (cmd_next != CMD_NONE);
        result.done_res  = done;
        result.rx_byte   = rx_hold_next;
        result.nak       = ack_sample_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_NONE;
            step_reg       <= '0;
            bits_reg       <= '0;
            div_reg        <= '0;
            shift_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_sample_reg <= 1'b0;
            ack_drive_reg  <= 1'b0;
            rx_hold_reg    <= '0;
        end
        else if (go)
        begin
            cmd_reg        <= cmd_next;
            step_reg       <= step_next;
            bits_reg       <= bits_next;
            div_reg        <= div_next;
            shift_reg      <= shift_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_sample_reg <= ack_sample_next;
            ack_drive_reg  <= ack_drive_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go && result.done_res |=> cmd_reg == CMD_NONE)
        else $error("command still active after done");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_NONE |-> step_reg == 5'd0)
        else $error("phase step nonzero while idle");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(cmd_reg) && $stable(step_reg) && $stable(div_reg))
        else $error("sequencer state moved without a tick");

    a_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> (cmd_reg != CMD_NONE) == $past(result.busy_res))
        else $error("busy flag disagrees with command state");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for i2c_master_bit_sequencer_top: tick driver, result monitor,
// APB register access and a cycle-accurate predictor of the SCL/SDA phase engine.
// Depends on i2cms_pkg and the RTL of the sequencer.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    // Register map: phase_ticks is the only register; addresses with bit 2 set are unmapped.
    localparam logic [2:0] ADDR_PHASE_TICKS = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    // Opcode values outside cmd_t; the block treats them as no operation.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Longest legal quiet stretch is a sender gap overlapping a receiver stall, plus the
    // two queue stages and an APB access. The limit is many times that.
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    cmd_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Ticks waiting for the driver, and the line levels predicted for each of them.
    in_item_t  pending_ticks[$];
    out_item_t expected_lines[$];

    // Predicted engine state, starting at the reset values.
    logic [7:0] eng_ticks   = PHASE_TICKS_RST;
    cmd_t       eng_cmd     = CMD_NONE;
    logic [4:0] eng_step    = '0;
    logic [3:0] eng_bits    = '0;
    logic [7:0] eng_div     = '0;
    logic [7:0] eng_shift   = '0;
    logic       eng_scl     = 1'b1;
    logic       eng_sda     = 1'b1;
    logic       eng_nak     = 1'b0;
    logic       eng_ack_drv = 1'b0;
    logic [7:0] eng_rx      = '0;

    int push_idle_pct = 0;
    int pop_idle_pct  = 0;
    int push_gap      = 0;
    int pop_gap       = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;
    int results_seen  = 0;
    int commands_sent = 0;
    out_item_t line_want;

    i2c_master_bit_sequencer_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd_item (cmd_item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    //------------------------------------------------------------------------
    // Predictor: advances the engine by one tick and returns the result
    // transaction the block must produce for that tick.
    //------------------------------------------------------------------------
    function automatic out_item_t step_sequencer(input in_item_t it);
        out_item_t  res;
        logic [3:0] pulses;
        int         span;
        int         data_ph;
        int         last_ph;
        int         bit_idx;
        logic       done;
        span = (eng_ticks == 8'd0) ? 1 : int'(eng_ticks);   // zero behaves as one
        done = 1'b0;

        // A command is only taken while idle; anything else is ignored.
        if (eng_cmd == CMD_NONE && it.opcode >= CMD_START && it.opcode <= CMD_CLEAR)
        begin
            eng_step = '0;
            eng_div  = '0;
            if (it.opcode == CMD_READ)
            begin
                pulses = (it.pulse_count > NORMAL_PULSES) ? NORMAL_PULSES : it.pulse_count;
                if (pulses == 4'd0)
                begin
                    // Empty read: finishes at once, no bus activity.
                    eng_rx = '0;
                    done   = 1'b1;
                end
                else
                begin
                    eng_bits    = pulses - 4'd1;
                    eng_shift   = '0;
                    eng_ack_drv = it.ack_level;
                    eng_cmd     = CMD_READ;
                end
            end
            else
            begin
                if (it.opcode == CMD_WRITE)
                    eng_shift = it.tx_byte;
                eng_cmd = cmd_t'(it.opcode);
            end
        end

        if (eng_cmd != CMD_NONE)
        begin
            data_ph = 2 * int'(eng_bits);
            // Line levels of the current phase.
            case (eng_cmd)
                CMD_START:
                begin
                    if (eng_step == 5'd0)
                        eng_sda = 1'b1;
                    else if (eng_step == 5'd1)
                        {eng_scl, eng_sda} = 2'b11;
                    else if (eng_step == 5'd2)
                        {eng_scl, eng_sda} = 2'b10;
                    else
                        {eng_scl, eng_sda} = 2'b00;
                end
                CMD_STOP:
                begin
                    if (eng_step == 5'd0)
                        eng_scl = 1'b0;
                    else if (eng_step == 5'd1)
                        {eng_scl, eng_sda} = 2'b00;
                    else if (eng_step == 5'd2)
                        {eng_scl, eng_sda} = 2'b10;
                    else
                        {eng_scl, eng_sda} = 2'b11;
                end
                CMD_WRITE:
                begin
                    if (eng_step < WR_DATA_PHASES)
                    begin
                        bit_idx = 7 - int'(eng_step[3:1]);
                        eng_scl = eng_step[0];
                        eng_sda = eng_shift[bit_idx];
                    end
                    else
                    begin
                        eng_scl = (eng_step == WR_ACK_HIGH);
                        eng_sda = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (eng_step < data_ph)
                        {eng_scl, eng_sda} = {eng_step[0], 1'b1};
                    else if (eng_step == data_ph)
                        {eng_scl, eng_sda} = {1'b0, eng_ack_drv};
                    else if (eng_step == data_ph + 1)
                        {eng_scl, eng_sda} = {1'b1, eng_ack_drv};
                    else
                        {eng_scl, eng_sda} = 2'b01;
                end
                CMD_CLEAR:
                begin
                    if (eng_step <= CLR_PULSE_END)
                        {eng_scl, eng_sda} = {eng_step[0], 1'b1};
                    else if (eng_step == CLR_STOP_LOW)
                        {eng_scl, eng_sda} = 2'b00;
                    else if (eng_step == CLR_STOP_HIGH)
                        {eng_scl, eng_sda} = 2'b10;
                    else
                        {eng_scl, eng_sda} = 2'b11;
                end
                default: ;
            endcase

            eng_div = eng_div + 8'd1;
            if (int'(eng_div) >= span)
            begin
                // Last tick of the phase: sample SDA where the phase calls for it.
                eng_div = '0;
                if (eng_cmd == CMD_WRITE && eng_step == WR_ACK_HIGH)
                    eng_nak = it.sda_in;
                else if (eng_cmd == CMD_READ && eng_step < data_ph && eng_step[0])
                    eng_shift = {eng_shift[6:0], it.sda_in};
                eng_step = eng_step + 5'd1;
                case (eng_cmd)
                    CMD_START: last_ph = int'(START_PHASES);
                    CMD_STOP:  last_ph = int'(STOP_PHASES);
                    CMD_WRITE: last_ph = int'(WRITE_PHASES);
                    CMD_READ:  last_ph = data_ph + int'(READ_TAIL);
                    CMD_CLEAR: last_ph = int'(CLEAR_PHASES);
                    default:   last_ph = 0;
                endcase
                if (eng_step >= last_ph)
                begin
                    if (eng_cmd == CMD_READ)
                        eng_rx = eng_shift;
                    eng_cmd  = CMD_NONE;
                    eng_step = '0;
                    done     = 1'b1;
                end
            end
        end

        res.scl_level = eng_scl;
        res.sda_level = eng_sda;
        res.busy_res  = (eng_cmd != CMD_NONE);
        res.done_res  = done;
        res.rx_byte   = eng_rx;
        res.nak       = eng_nak;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("ERROR: transaction %0d %s expected 0x%0h got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    //------------------------------------------------------------------------
    // Stimulus helpers. Each tick is predicted as it is queued; the stream
    // is strictly ordered and the register only changes once drained.
    //------------------------------------------------------------------------
    function automatic logic [2:0] idle_opcode();
        case ($urandom_range(0, 2))
            0:       return CMD_NONE;
            1:       return OP_RSVD6;
            default: return OP_RSVD7;
        endcase
    endfunction

    task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input logic [3:0] pc);
        in_item_t it;
        it.opcode      = op;
        it.tx_byte     = tx;
        it.ack_level   = ack;
        it.pulse_count = pc;
        it.sda_in      = 1'($urandom_range(0, 1));
        expected_lines.push_back(step_sequencer(it));
        pending_ticks.push_back(it);
    endtask

    // One command, ticks until the engine is idle again, then up to two idle
    // ticks. noise_pct of the filler ticks carry random opcodes, which the busy engine must ignore.
    task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                               input logic [3:0] pc, input int noise_pct);
        send_tick(op, tx, ack, pc);
        while (eng_cmd != CMD_NONE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 4'($urandom));
            else
                send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 4'($urandom));
        end
        repeat ($urandom_range(0, 2))
            send_tick(idle_opcode(), 8'($urandom), 1'($urandom), 4'($urandom));
        if (op >= CMD_START && op <= CMD_CLEAR)
            commands_sent++;
    endtask

    // Well-formed bus transaction: start, address, a few data bytes with
    // an occasional repeated start, stop. Read direction follows the address LSB.
    task automatic bus_transfer();
        logic [7:0] addr;
        logic [3:0] pulses;
        logic       ack;
        int         n;
        addr = 8'($urandom);
        n    = $urandom_range(1, 4);
        run_command(CMD_START, 8'($urandom), 1'($urandom), 4'($urandom), 5);
        run_command(CMD_WRITE, addr, 1'($urandom), 4'($urandom), 5);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                addr = 8'($urandom);
                run_command(CMD_START, 8'($urandom), 1'($urandom), 4'($urandom), 5);
                run_command(CMD_WRITE, addr, 1'($urandom), 4'($urandom), 5);
            end
            if (addr[0])
            begin
                // Mostly full bytes with NACK on the last one; sometimes odd counts.
                pulses = ($urandom_range(0, 7) == 0) ? 4'($urandom) : NORMAL_PULSES;
                ack    = ($urandom_range(0, 7) == 0) ? 1'($urandom) : (k == n - 1);
                run_command(CMD_READ, 8'($urandom), ack, pulses, 5);
            end
            else
                run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 4'($urandom), 5);
        end
        run_command(CMD_STOP, 8'($urandom), 1'($urandom), 4'($urandom), 5);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PHASE_TICKS)
            eng_ticks = data[7:0];
    endtask

    // Reads phase_ticks back and compares it with the predicted setting.
    task automatic check_ticks_reg();
        logic [31:0] data;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PHASE_TICKS;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("phase_ticks readback", eng_ticks, data[7:0]);
    endtask

    task automatic wait_drained();
        while (expected_lines.size() != 0 || pending_ticks.size() != 0)
            @(posedge clk);
    endtask

    // One random section at a given bus rate and idling mix.
    task automatic random_section(input logic [7:0] ticks, input int quota,
                                  input int push_pct, input int pop_pct);
        reg_write(ADDR_PHASE_TICKS, {24'($urandom), ticks});
        check_ticks_reg();
        push_idle_pct = push_pct;
        pop_idle_pct  = pop_pct;
        commands_sent = 0;
        while (commands_sent < quota)
        begin
            if ($urandom_range(0, 99) < 85)
                bus_transfer();
            else
                run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                            4'($urandom), 20);
        end
        wait_drained();
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of the register, then directed commands at the fastest rate.
        check_ticks_reg();
        reg_write(ADDR_PHASE_TICKS, 32'd1);
        check_ticks_reg();
        push_idle_pct = 10;
        pop_idle_pct  = 10;
        send_tick(CMD_NONE, 8'hFF, 1'b1, 4'hF);
        send_tick(OP_RSVD6, 8'h00, 1'b0, 4'h0);
        send_tick(OP_RSVD7, 8'hFF, 1'b1, 4'hF);
        run_command(CMD_STOP, 8'h00, 1'b0, 4'h0, 0);              // stop from idle bus
        run_command(CMD_START, 8'h00, 1'b0, 4'h0, 0);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 4'hF, 0);
        run_command(CMD_WRITE, 8'h00, 1'b1, 4'h0, 0);
        run_command(CMD_READ, 8'hFF, 1'b0, NORMAL_PULSES, 0);
        run_command(CMD_READ, 8'h00, 1'b1, 4'd15, 0);             // count saturates at nine
        run_command(CMD_READ, 8'h5A, 1'b0, 4'd10, 0);
        run_command(CMD_READ, 8'hA5, 1'b1, 4'd1, 0);              // acknowledge slot only
        run_command(CMD_READ, 8'hFF, 1'b0, 4'd0, 0);              // empty read, instant done
        run_command(CMD_READ, 8'h00, 1'b1, 4'd2, 0);
        run_command(CMD_START, 8'hFF, 1'b1, 4'hF, 100);           // repeated start, busy noise
        run_command(CMD_WRITE, 8'hA5, 1'b1, 4'h9, 100);
        run_command(CMD_READ, 8'h3C, 1'b1, NORMAL_PULSES, 100);
        run_command(CMD_STOP, 8'hFF, 1'b0, 4'h0, 100);
        run_command(CMD_CLEAR, 8'h00, 1'b1, 4'hF, 100);
        run_command(CMD_CLEAR, 8'hFF, 1'b0, 4'h0, 0);
        run_command(CMD_READ, 8'h00, 1'b0, 4'd0, 0);
        wait_drained();

        // A write to an unmapped address must leave phase_ticks alone.
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FF37);
        check_ticks_reg();

        // Random sections at fast rates; zero acts as one, two exercises the divider.
        random_section(8'd1, 12, 5, 25);
        random_section(8'd0, 10, 25, 5);
        random_section(8'd2, 5, 25, 25);
        random_section(8'd1, 12, 0, 0);                           // full rate, no idling

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    //------------------------------------------------------------------------
    // Driver: one tick transaction per cycle from pending_ticks, with random
    // idle bursts. push holds while the block is full.
    //------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!push || !full))
        begin
            if (push_gap != 0)
            begin
                push     <= 1'b0;
                push_gap <= push_gap - 1;
            end
            else if (push_idle_pct != 0 && $urandom_range(0, 99) < push_idle_pct)
            begin
                push     <= 1'b0;
                push_gap <= $urandom_range(0, 12);
            end
            else if (pending_ticks.size() != 0)
            begin
                cmd_item <= pending_ticks.pop_front();
                push     <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    //------------------------------------------------------------------------
    // Monitor: each popped result is checked against the oldest prediction;
    // pop stalls in random bursts like the driver.
    //------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_lines.size() == 0)
                    check_field("unexpected transaction", 0, 1);
                else
                begin
                    line_want = expected_lines.pop_front();
                    check_field("scl_level", line_want.scl_level, result.scl_level);
                    check_field("sda_level", line_want.sda_level, result.sda_level);
                    check_field("busy_res", line_want.busy_res, result.busy_res);
                    check_field("done_res", line_want.done_res, result.done_res);
                    check_field("rx_byte", line_want.rx_byte, result.rx_byte);
                    check_field("nak", line_want.nak, result.nak);
                end
                results_seen++;
            end

            if (pop_gap != 0)
            begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct)
            begin
                pop     <= 1'b0;
                pop_gap <= $urandom_range(0, 12);
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: ends the run if neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

[sim.f]
rtl/i2cms_pkg.sv
rtl/i2cms_fifo.sv
rtl/i2cms_front.sv
rtl/i2cms_engine.sv
rtl/i2c_master_bit_sequencer_top.sv
tb/testbench.sv
